### rtl/core/hpie_pkg.sv
// ----------------------------------------------------------------------------
// hpie_pkg
// Shared types, constants and helpers for the HPACK prefixed-integer encoder.
// ----------------------------------------------------------------------------
package hpie_pkg;

    // Width of the value actually encoded (low bits of int_value), 8 to 64
    localparam int VALUE_WIDTH = 64;

    localparam int          GROUP_BITS = 7;
    localparam logic [7:0]  CONT_FLAG  = 8'd128;
    localparam logic [6:0]  GROUP_MASK = 7'd127;

    // Input item
    typedef struct packed {
        logic [63:0] int_value;
        logic [7:0]  instruction_bits;
        logic [3:0]  prefix_bits;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_first;
        logic load_group;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic fits_prefix;
        logic more_groups;
    } dp_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } enc_state_t;

    // Prefix mask 2^n - 1, with n clamped to 1..8
    function automatic logic [7:0] prefix_mask(input logic [3:0] n);
        logic [7:0] m;
        begin
            m = 8'hFF;
            priority if (n == 4'd0)
            begin
                m = 8'h01;
            end
            else if (n >= 4'd8)
            begin
                m = 8'hFF;
            end
            else
            begin
                m = 8'((9'd1 << n) - 9'd1);
            end
            return m;
        end
    endfunction

endpackage

### rtl/core/hpie_ctrl.sv
// ----------------------------------------------------------------------------
// hpie_ctrl
// Sequencer: takes an item, then steps the datapath through the 7-bit groups.
// ----------------------------------------------------------------------------
module hpie_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                int_valid,
    output logic                int_stall,
    input  hpie_pkg::dp_status_t status,
    output hpie_pkg::dp_cmd_t    cmd
);
    import hpie_pkg::*;

    enc_state_t state_reg;
    enc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.load_first = 1'b0;
        cmd.load_group = 1'b0;
        int_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                int_stall = !status.out_free;
                if (int_valid && status.out_free)
                begin
                    cmd.load_first = 1'b1;
                    if (!status.fits_prefix)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_group = 1'b1;
                    if (!status.more_groups)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/hpie_dp.sv
// ----------------------------------------------------------------------------
// hpie_dp
// Datapath: first-byte build, remainder register and output byte register.
// ----------------------------------------------------------------------------
module hpie_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpie_pkg::in_item_t   int_item,
    output logic                 byte_valid,
    input  logic                 byte_stall,
    output hpie_pkg::out_item_t  byte_item,
    input  hpie_pkg::dp_cmd_t    cmd,
    output hpie_pkg::dp_status_t status
);
    import hpie_pkg::*;

    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_reg;
    out_item_t              out_next;

    logic [VALUE_WIDTH-1:0] value_w;
    logic [7:0]             pmask;
    logic [7:0]             first;
    logic                   fits;
    logic                   more;

    // First byte and prefix test
    always_comb
    begin
        value_w = int_item.int_value[VALUE_WIDTH-1:0];
        pmask   = prefix_mask(int_item.prefix_bits);
        first   = int_item.instruction_bits & ~pmask;
        fits    = value_w < VALUE_WIDTH'(pmask);
        more    = |rem_reg[VALUE_WIDTH-1:GROUP_BITS];
    end

    // Next remainder and output byte
    always_comb
    begin
        rem_next = rem_reg;
        out_next = out_reg;
        priority if (cmd.load_first)
        begin
            if (fits)
            begin
                out_next.out_byte  = first | value_w[7:0];
                out_next.last_byte = 1'b1;
            end
            else
            begin
                out_next.out_byte  = first | pmask;
                out_next.last_byte = 1'b0;
                rem_next           = value_w - VALUE_WIDTH'(pmask);
            end
        end
        else if (cmd.load_group)
        begin
            if (more)
            begin
                out_next.out_byte  = CONT_FLAG | {1'b0, rem_reg[6:0] & GROUP_MASK};
                out_next.last_byte = 1'b0;
                rem_next           = rem_reg >> GROUP_BITS;
            end
            else
            begin
                out_next.out_byte  = {1'b0, rem_reg[6:0]};
                out_next.last_byte = 1'b1;
            end
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.load_first || cmd.load_group)
        begin
            out_valid_next = 1'b1;
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            out_reg <= out_next;
        end
    end

    assign byte_valid         = out_valid_reg;
    assign byte_item          = out_reg;
    assign status.out_free    = !out_valid_reg || !byte_stall;
    assign status.fits_prefix = fits;
    assign status.more_groups = more;

endmodule

### rtl/core/hpack_prefix_integer_encoder_core.sv
// ----------------------------------------------------------------------------
// hpack_prefix_integer_encoder_core
// HPACK n-bit prefix integer encoder: one integer in, 1 to 11 bytes out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  int      in   int_valid/int_stall   in_item_t  (value, instruction, prefix)
//  byte     out  byte_valid/byte_stall out_item_t (out_byte, last_byte)
//
//  An item emits one byte when the value fits the prefix, otherwise
//  1 + the count of 7-bit groups in value minus mask
//  (at least one group, so 2 to 11 bytes).
//  The single output register paces all: one byte per cycle, unless stalled.
//  A new item is taken in the cycle its predecessor's last byte is handed on.
//  rst_n clears the sequencer and the output valid; no item is lost on stall.
// ----------------------------------------------------------------------------
module hpack_prefix_integer_encoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                int_valid,
    output logic                int_stall,
    input  hpie_pkg::in_item_t  int_item,
    output logic                byte_valid,
    input  logic                byte_stall,
    output hpie_pkg::out_item_t byte_item
);
    import hpie_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hpie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .int_valid (int_valid),
        .int_stall (int_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hpie_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .int_item   (int_item),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cmd        (cmd),
        .status     (status)
    );

    // An accepted item always shows a byte next cycle
    a_accept_shows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        int_valid && !int_stall |=> byte_valid)
        else $error("accepted item produced no byte");

    // No new item while a non-final byte is pending
    a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_item.last_byte |-> int_stall)
        else $error("item accepted in the middle of an encoding");

    // Only one datapath load per cycle
    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_first, cmd.load_group}))
        else $error("conflicting datapath loads");

endmodule
